// File: sv/sorted_set_statistics_top_assert.svh
// Assertion macros used by the checker of the sorted set statistics block.
`ifndef SORTED_SET_STATISTICS_TOP_ASSERT_SVH
`define SORTED_SET_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: sv/sss_pkg.sv
// Package with the constants, types and control structs of the sorted set statistics block.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SUM_W        = DATA_W + IDX_W;
    localparam int STEP_W       = $clog2(SUM_W + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [STEP_W-1:0]        step_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;
        logic start;
        logic scan_step;
        logic emit_shift;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic emit_final;
    } stat_t;

endpackage

`default_nettype wire

// File: sv/sss_ctrl.sv
// Controller state machine: load, statistics scan and result emission.
`timescale 1ns / 1ps
`default_nettype none

module sss_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          last,
    input  wire logic          result_stall,
    input  wire sss_pkg::stat_t stat,
    output sss_pkg::cmd_t      cmd,
    output logic               item_stall,
    output logic               result_valid
);

    sss_pkg::state_t state_reg;
    sss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sss_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sss_pkg::ST_LOAD:
            begin
                if (item_valid && last)
                begin
                    state_next = sss_pkg::ST_START;
                end
            end
            sss_pkg::ST_START:
            begin
                state_next = sss_pkg::ST_SCAN;
            end
            sss_pkg::ST_SCAN:
            begin
                if (stat.scan_done && stat.div_done)
                begin
                    state_next = sss_pkg::ST_EMIT;
                end
            end
            sss_pkg::ST_EMIT:
            begin
                if (!result_stall && stat.emit_final)
                begin
                    state_next = sss_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sss_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        item_stall   = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            sss_pkg::ST_LOAD:
            begin
                item_stall = 1'b0;
                cmd.insert = item_valid;
            end
            sss_pkg::ST_START:
            begin
                cmd.start = 1'b1;
            end
            sss_pkg::ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
            end
            sss_pkg::ST_EMIT:
            begin
                result_valid   = 1'b1;
                cmd.emit_shift = !result_stall;
                cmd.clear      = !result_stall && stat.emit_final;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sss_div.sv
// Restoring divider that forms the mean as sum over count, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none

module sss_div
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sss_pkg::sum_t dividend,
    input  wire sss_pkg::cnt_t divisor,
    output logic               done,
    output sss_pkg::data_t     quotient
);

    logic [sss_pkg::SUM_W-1:0] q_reg;
    logic [sss_pkg::SUM_W-1:0] q_next;
    sss_pkg::cnt_t             rem_reg;
    sss_pkg::cnt_t             rem_next;
    sss_pkg::cnt_t             d_reg;
    logic                      neg_reg;
    sss_pkg::step_t            step_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [sss_pkg::CNT_W:0]   trial;
    logic [sss_pkg::CNT_W:0]   diff;
    logic                      fits;
    logic [sss_pkg::SUM_W-1:0] mag;
    logic [sss_pkg::SUM_W-1:0] q_signed;

    // The sign is handled apart; the magnitude of the most negative sum still fits unsigned.
    assign mag = dividend[sss_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;

    assign trial = {rem_reg, q_reg[sss_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        rem_next = fits ? diff[sss_pkg::CNT_W-1:0] : trial[sss_pkg::CNT_W-1:0];
        q_next   = {q_reg[sss_pkg::SUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == sss_pkg::step_t'(sss_pkg::SUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[sss_pkg::SUM_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[sss_pkg::DATA_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: sv/sss_datapath.sv
// Datapath: sorted insertion cell chain, running sum, statistics capture and result fields.
`timescale 1ns / 1ps
`default_nettype none

module sss_datapath
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sss_pkg::cmd_t  cmd,
    input  wire sss_pkg::data_t value,
    output sss_pkg::stat_t      stat,
    output sss_pkg::data_t      sorted_value,
    output logic [sss_pkg::POS_W-1:0] position,
    output logic                final_result,
    output sss_pkg::data_t      minimum,
    output sss_pkg::data_t      maximum,
    output sss_pkg::data_t      mean,
    output sss_pkg::data_t      median,
    output logic                dropped
);

    localparam int N = sss_pkg::MAX_ELEMENTS;

    sss_pkg::data_t  cell_reg [N];
    logic [N-1:0]    vld_reg;
    logic [N-1:0]    vld_next;
    logic [N:0]      vld_ext;
    logic [N-1:0]    ge;
    logic [N:0]      ge_ext;
    logic [N-1:0]    prev_ge;

    sss_pkg::cnt_t   count_reg;
    sss_pkg::sum_t   sum_reg;
    logic            ovf_reg;
    sss_pkg::idx_t   scan_reg;
    logic            scan_fin_reg;
    sss_pkg::cnt_t   emit_reg;
    sss_pkg::data_t  min_reg;
    sss_pkg::data_t  max_reg;
    sss_pkg::data_t  med_a_reg;
    sss_pkg::data_t  med_b_reg;

    logic            store;
    logic            shift;
    sss_pkg::cnt_t   scan_k;
    sss_pkg::cnt_t   half;
    logic signed [sss_pkg::DATA_W:0] med_sum;
    logic signed [sss_pkg::DATA_W:0] med_adj;
    logic            div_done;
    sss_pkg::data_t  quotient;

    assign store = cmd.insert && (count_reg != sss_pkg::cnt_t'(N));
    // Scanning and emitting both rotate the chain toward cell zero.
    assign shift = cmd.scan_step || cmd.emit_shift;

    // The chain is kept in descending order with valid entries at the front.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ge[i] = vld_reg[i] && (cell_reg[i] >= value);
        end
    end

    assign ge_ext  = {ge, 1'b1};
    assign prev_ge = ge_ext[N-1:0];
    assign vld_ext = {vld_reg, 1'b1};

    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.clear)
        begin
            vld_next = '0;
        end
        else if (store)
        begin
            vld_next = vld_ext[N-1:0];
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        sss_pkg::data_t up;
        sss_pkg::data_t down;

        if (i == 0)
        begin : g_first
            assign up = value;
        end
        else
        begin : g_mid
            assign up = cell_reg[i-1];
        end

        if (i == N - 1)
        begin : g_wrap
            assign down = cell_reg[0];
        end
        else
        begin : g_next
            assign down = cell_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (store)
            begin
                if (!ge[i])
                begin
                    cell_reg[i] <= prev_ge[i] ? value : up;
                end
            end
            else if (shift)
            begin
                cell_reg[i] <= down;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            scan_reg     <= '0;
            scan_fin_reg <= 1'b0;
            emit_reg     <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cmd.clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (store)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + sss_pkg::sum_t'(value);
            end
            else if (cmd.insert)
            begin
                ovf_reg <= 1'b1;
            end

            if (cmd.start)
            begin
                scan_reg     <= '0;
                scan_fin_reg <= 1'b0;
                emit_reg     <= '0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_reg     <= scan_reg + 1'b1;
                    scan_fin_reg <= (scan_reg == sss_pkg::idx_t'(N - 1));
                end
                if (cmd.emit_shift)
                begin
                    emit_reg <= emit_reg + 1'b1;
                end
            end
        end
    end

    // After k rotations cell zero holds the element of sorted rank k.
    assign scan_k = sss_pkg::cnt_t'(scan_reg);
    assign half   = count_reg >> 1;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            if (scan_k == '0)
            begin
                max_reg <= cell_reg[0];
            end
            if (scan_k == count_reg - 1'b1)
            begin
                min_reg <= cell_reg[0];
            end
            if (scan_k == half)
            begin
                med_a_reg <= cell_reg[0];
            end
            if (scan_k + 1'b1 == half)
            begin
                med_b_reg <= cell_reg[0];
            end
        end
    end

    sss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // A negative pair sum is nudged up by one so the shift truncates toward zero.
    assign med_sum = {med_a_reg[sss_pkg::DATA_W-1], med_a_reg}
                   + {med_b_reg[sss_pkg::DATA_W-1], med_b_reg};
    assign med_adj = med_sum + {{sss_pkg::DATA_W{1'b0}}, med_sum[sss_pkg::DATA_W]};

    assign stat.scan_done  = scan_fin_reg;
    assign stat.div_done   = div_done;
    assign stat.emit_final = (emit_reg == count_reg - 1'b1);

    assign sorted_value = cell_reg[0];
    assign position     = emit_reg[sss_pkg::POS_W-1:0];
    assign final_result = stat.emit_final;
    assign minimum      = min_reg;
    assign maximum      = max_reg;
    assign mean         = quotient;
    assign median       = count_reg[0] ? med_a_reg : med_adj[sss_pkg::DATA_W:1];
    assign dropped      = ovf_reg;

endmodule

`default_nettype wire

// File: sv/sorted_set_statistics_top.sv
// Top level of the sorted set statistics block: controller plus datapath.
//
//  Channel  | Valid         | Stall         | Payload
//  ---------+---------------+---------------+-----------------------------------------------
//  item     | item_valid    | item_stall    | value, last
//  result   | result_valid  | result_stall  | sorted_value, position, final_result,
//           |               |               | minimum, maximum, mean, median, dropped
//
// Loading takes one transaction per cycle; each element is inserted into the sorted cell chain.
// After the last item come a setup state, a rotation scan through all MAX_ELEMENTS cells that
// captures minimum, maximum and median, and a check of the scan end.
// The mean divider runs alongside the scan and never sets the latency. Results leave largest
// first, one per cycle unless stalled; item_stall holds until the final one completes.
// Reset clears the count, sum, drop flag, valid bits and controller state.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_statistics_top
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic signed [31:0]           value,
    input  wire logic                         last,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic signed [31:0]                sorted_value,
    output logic [5:0]                        position,
    output logic                              final_result,
    output logic signed [31:0]                minimum,
    output logic signed [31:0]                maximum,
    output logic signed [31:0]                mean,
    output logic signed [31:0]                median,
    output logic                              dropped
);

    sss_pkg::cmd_t  cmd;
    sss_pkg::stat_t stat;

    sss_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .last         (last),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd),
        .item_stall   (item_stall),
        .result_valid (result_valid)
    );

    sss_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .stat         (stat),
        .sorted_value (sorted_value),
        .position     (position),
        .final_result (final_result),
        .minimum      (minimum),
        .maximum      (maximum),
        .mean         (mean),
        .median       (median),
        .dropped      (dropped)
    );

endmodule

`default_nettype wire

// File: sv/sss_checker.sv
// Port-level checker for the sorted set statistics block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_set_statistics_top_assert.svh"

module sss_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire logic               last,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic signed [31:0] sorted_value,
    input wire logic [5:0]         position,
    input wire logic               final_result
);

    logic result_held;
    logic more_results;

    assign result_held  = result_valid && result_stall;
    assign more_results = result_valid && !result_stall && !final_result;

    // A stalled result keeps its element and rank.
    `SSS_ASSERT_NXT(a_result_hold, result_held, result_valid && $stable(sorted_value) && $stable(position))

    // No new item is taken while results of the current set are being shown.
    `SSS_ASSERT_IMP(a_no_overlap, result_valid, item_stall)

    // Closing a set stops the item channel at once.
    `SSS_ASSERT_NXT(a_close_set, item_valid && !item_stall && last, item_stall)

    // Results of one run come back to back with ranks counting up.
    `SSS_ASSERT_NXT(a_rank_step, more_results, result_valid && position == $past(position) + 6'd1)

endmodule

bind sorted_set_statistics_top sss_checker u_sss_checker (.*);

`default_nettype wire
